// File: rtl/bbda_pkg.sv
// Shared constants, payload types and the density palette for the block-density ASCII block.
`timescale 1ns / 1ps
package bbda_pkg;

  localparam int SRC_WIDTH     = 160;
  localparam int SRC_HEIGHT    = 120;
  localparam int CELLS_ACROSS  = 75;
  localparam int CELLS_DOWN    = 23;
  localparam int CELL_WIDTH    = 2;
  localparam int CELL_HEIGHT   = 5;
  localparam int PX_BITS       = 8;
  localparam int BYTES_PER_ROW = (SRC_WIDTH + PX_BITS - 1) / PX_BITS;
  localparam int ACTIVE_COLS   = CELLS_ACROSS * CELL_WIDTH;
  localparam int LANES         = PX_BITS / CELL_WIDTH;
  localparam int SUM_ROWS      = (CELLS_ACROSS + LANES - 1) / LANES;
  localparam int MAX_RESULTS   = 4;

  localparam int SUM_W      = 4;
  localparam int CODE_W     = 7;
  localparam int BYTE_W     = 5;
  localparam int ROW_W      = 3;
  localparam int BAND_W     = 5;
  localparam int COL_W      = 9;
  localparam int CELL_IDX_W = 7;
  localparam int CNT_W      = 3;
  localparam int IDX_W      = 2;
  localparam int LINE_W     = 10;

  localparam logic [SUM_W-1:0]  SUM_MAX      = 4'd15;
  localparam logic [CODE_W-1:0] NEWLINE_CODE = 7'd10;

  typedef struct packed {
    logic [PX_BITS-1:0] pixel_byte;
    logic               start_of_frame;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last_of_run;
    logic              end_of_frame;
  } out_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             emit_row;
  } lane_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic              emit;
    logic [CODE_W-1:0] code;
  } lane_res_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][CODE_W-1:0] codes;
    logic [CNT_W-1:0]                   count;
    logic                               eof;
  } group_t;

  // Density palette " ..::-+*##@"; counts above ten read as the top entry.
  function automatic logic [CODE_W-1:0] palette_code(input logic [SUM_W-1:0] s);
    logic [CODE_W-1:0] c;
    begin
      case (s) inside
        4'd0:          c = 7'h20;
        4'd1, 4'd2:    c = 7'h2E;
        4'd3, 4'd4:    c = 7'h3A;
        4'd5:          c = 7'h2D;
        4'd6:          c = 7'h2B;
        4'd7:          c = 7'h2A;
        4'd8, 4'd9:    c = 7'h23;
        [4'd10:4'd15]: c = 7'h40;
        default:       c = 7'h40;
      endcase
      return c;
    end
  endfunction

endpackage

// File: rtl/bbda_lane.sv
// One cell lane: accumulate the lane's pixels into its cell sum and form its character.
`timescale 1ns / 1ps
module bbda_lane
  import bbda_pkg::*;
(
  input  lane_ctl_t              ctl,
  input  logic [SUM_W-1:0]       old_sum,
  input  logic [CELL_WIDTH-1:0]  pix,
  output lane_res_t              res
);

  logic [SUM_W-1:0] sum;
  logic             last_active;

  always_comb begin
    sum = old_sum;
    for (int j = 0; j < CELL_WIDTH; j++) begin
      if ((ctl.col + COL_W'(j)) < COL_W'(ACTIVE_COLS) && pix[CELL_WIDTH-1-j] &&
          sum != SUM_MAX) begin
        sum = sum + SUM_W'(1);
      end
    end
    last_active = (ctl.col + COL_W'(CELL_WIDTH - 1)) < COL_W'(ACTIVE_COLS);
    res.emit = ctl.emit_row && last_active;
    res.code = palette_code(sum);
    // Drop the sum once the cell's character goes out.
    res.sum  = res.emit ? '0 : sum;
  end

endmodule

// File: rtl/bbda_merge.sv
// Merge stage: pack the lanes' characters and the band newline into one held group.
`timescale 1ns / 1ps
module bbda_merge
  import bbda_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  lane_res_t [LANES-1:0]   lres,
  input  logic [BYTE_W-1:0]       cur_byte,
  input  logic                    band_last,
  input  logic                    take,
  output logic                    grp_valid,
  output group_t                  grp
);

  group_t           grp_next;
  logic [CNT_W-1:0] n;
  logic             is_last_cell;

  always_comb begin
    grp_next.codes = '0;
    grp_next.eof   = 1'b0;
    n              = '0;
    is_last_cell   = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      is_last_cell = (CELL_IDX_W'(cur_byte) * CELL_IDX_W'(LANES) + CELL_IDX_W'(l))
                     == CELL_IDX_W'(CELLS_ACROSS - 1);
      if (lres[l].emit) begin
        if (n < CNT_W'(MAX_RESULTS)) begin
          grp_next.codes[n[IDX_W-1:0]] = lres[l].code;
          n = n + CNT_W'(1);
        end
        if (is_last_cell && n < CNT_W'(MAX_RESULTS)) begin
          grp_next.codes[n[IDX_W-1:0]] = NEWLINE_CODE;
          grp_next.eof = band_last;
          n = n + CNT_W'(1);
        end
      end
    end
    grp_next.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (accept && n != '0) begin
      grp_valid <= 1'b1;
    end else if (take) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n != '0) begin
      grp <= grp_next;
    end
  end

endmodule

// File: rtl/bbda_serial.sv
// Serializer: a group's characters go out from registers, one per cycle unless ch stalls.
`timescale 1ns / 1ps
module bbda_serial
  import bbda_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   grp_valid,
  input  group_t grp,
  output logic   take,
  output logic   ch_valid,
  input  logic   ch_stall,
  output out_t   ch_item
);

  group_t           cur;
  logic [IDX_W-1:0] idx;
  logic             last;
  logic             fire;

  assign last = (idx == IDX_W'(cur.count - CNT_W'(1)));
  assign fire = ch_valid && !ch_stall;
  assign take = grp_valid && (!ch_valid || (fire && last));

  assign ch_item.char_code    = cur.codes[idx];
  assign ch_item.last_of_run  = last;
  assign ch_item.end_of_frame = cur.eof && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
      idx      <= '0;
    end else if (take) begin
      ch_valid <= 1'b1;
      idx      <= '0;
    end else if (fire) begin
      if (last) begin
        ch_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= grp;
    end
  end

endmodule

// File: rtl/bitmap_block_density_to_ascii.sv
// Top level of the block-density ASCII downsampler: position tracking, cell sums, lanes.
//
// Input channel px: one item per packed pixel byte (bit 7 leftmost), 20 bytes per row,
// 120 rows per frame; start_of_frame on an item restarts the position at row 0, byte 0
// and clears all cell sums before that byte counts.
// Output channel ch: one ASCII item per cell of 2x5 pixels (75 across, 23 down), plus a
// newline after the rightmost cell of each band; last_of_run marks the final item caused
// by an input byte, end_of_frame the newline closing the last band.
// Only the fifth row of a band produces items: each such byte gives up to four items.
// Throughput: one byte per cycle on rows that produce nothing, unless px stalls on a full
// group register; a fifth-row byte's items, up to four, leave one at a time, as the
// single-character output port sets the pace. With the output idle, the first item of a
// byte passes the group register, then the output register, before it is offered.
// A held group register sits between the lanes and the output register, so the next
// byte is taken while the previous byte's characters still drain.
// When ch is stalled, the output item holds; once the group register is also full, px
// stalls. Reset (synchronous, rst high) empties both stages and returns to frame start.
`timescale 1ns / 1ps
module bitmap_block_density_to_ascii
  import bbda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic px_valid,
  output logic px_stall,
  input  in_t  px_item,
  output logic ch_valid,
  input  logic ch_stall,
  output out_t ch_item
);

  // Position counters.
  logic [BYTE_W-1:0] byte_in_row, byte_in_row_next;
  logic [ROW_W-1:0]  row_in_band, row_in_band_next;
  logic [BAND_W-1:0] band_index,  band_index_next;

  // Cell sums, one row of LANES cells per input byte position, with a valid bit per row
  // so that a frame restart clears them all at once.
  logic [SUM_ROWS-1:0][LANES-1:0][SUM_W-1:0] sums;
  logic [SUM_ROWS-1:0]                       sum_valid, sum_valid_next;

  logic                          accept;
  logic                          sof;
  logic [BYTE_W-1:0]             cur_byte;
  logic [ROW_W-1:0]              cur_row;
  logic [BAND_W-1:0]             cur_band;
  logic                          band_ok;
  logic                          slot_ok;
  logic                          wrap;
  logic [LANES-1:0][SUM_W-1:0]   old_row;
  lane_ctl_t [LANES-1:0]         lctl;
  lane_res_t [LANES-1:0]         lres;

  logic   grp_valid;
  group_t grp;
  logic   take;

  assign accept   = px_valid && !px_stall;
  assign px_stall = grp_valid && !take;
  assign sof      = px_item.start_of_frame;

  // A start of frame acts before the byte is used.
  assign cur_byte = sof ? '0 : byte_in_row;
  assign cur_row  = sof ? '0 : row_in_band;
  assign cur_band = sof ? '0 : band_index;
  assign band_ok  = cur_band < BAND_W'(CELLS_DOWN);
  assign slot_ok  = cur_byte < BYTE_W'(SUM_ROWS);

  always_comb begin
    old_row = '0;
    if (slot_ok && !sof && sum_valid[cur_byte]) begin
      old_row = sums[cur_byte];
    end
  end

  // One lane per cell covered by the byte.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lctl[l].col      = (COL_W'(cur_byte) << 3) + COL_W'(l * CELL_WIDTH);
    assign lctl[l].emit_row = band_ok && (cur_row == ROW_W'(CELL_HEIGHT - 1));

    bbda_lane u_lane (
      .ctl     (lctl[l]),
      .old_sum (old_row[l]),
      .pix     (px_item.pixel_byte[PX_BITS-1-l*CELL_WIDTH -: CELL_WIDTH]),
      .res     (lres[l])
    );
  end

  bbda_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept && band_ok),
    .lres      (lres),
    .cur_byte  (cur_byte),
    .band_last (cur_band == BAND_W'(CELLS_DOWN - 1)),
    .take      (take),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  bbda_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .take      (take),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .ch_item   (ch_item)
  );

  // Advance the position; wrap to frame start after the last row.
  always_comb begin
    byte_in_row_next = cur_byte + BYTE_W'(1);
    row_in_band_next = cur_row;
    band_index_next  = cur_band;
    if (byte_in_row_next == BYTE_W'(BYTES_PER_ROW)) begin
      byte_in_row_next = '0;
      row_in_band_next = cur_row + ROW_W'(1);
      if (row_in_band_next == ROW_W'(CELL_HEIGHT)) begin
        row_in_band_next = '0;
        band_index_next  = cur_band + BAND_W'(1);
      end
    end
    wrap = (LINE_W'(band_index_next) * LINE_W'(CELL_HEIGHT) + LINE_W'(row_in_band_next))
           >= LINE_W'(SRC_HEIGHT);
    if (wrap) begin
      byte_in_row_next = '0;
      row_in_band_next = '0;
      band_index_next  = '0;
    end

    sum_valid_next = sof ? '0 : sum_valid;
    if (band_ok && slot_ok) begin
      sum_valid_next[cur_byte] = 1'b1;
    end
    if (wrap) begin
      sum_valid_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row <= '0;
      row_in_band <= '0;
      band_index  <= '0;
      sum_valid   <= '0;
    end else if (accept) begin
      byte_in_row <= byte_in_row_next;
      row_in_band <= row_in_band_next;
      band_index  <= band_index_next;
      sum_valid   <= sum_valid_next;
    end
  end

  // Write back the lanes' sums for this byte position.
  always_ff @(posedge clk) begin
    if (accept && band_ok && slot_ok) begin
      for (int l = 0; l < LANES; l++) begin
        sums[cur_byte][l] <= lres[l].sum;
      end
    end
  end

endmodule

// File: rtl/bbda_checker.sv
// Port-level checks for the block-density ASCII block, bound to the top level.
`timescale 1ns / 1ps
module bbda_checker
  import bbda_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic px_valid,
  input logic px_stall,
  input in_t  px_item,
  input logic ch_valid,
  input logic ch_stall,
  input out_t ch_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_stall |=> ch_valid && $stable(ch_item))
    else $error("output item changed while stalled");

  a_eof_newline: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_item.end_of_frame |-> ch_item.last_of_run &&
    ch_item.char_code == NEWLINE_CODE)
    else $error("end of frame not on a closing newline");

  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_item.char_code == NEWLINE_CODE |-> ch_item.last_of_run)
    else $error("newline not last item of its byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !ch_valid && !px_stall)
    else $error("output not empty after reset");

endmodule

bind bitmap_block_density_to_ascii bbda_checker u_bbda_checker (.*);
